### rtl/core/ctb_pkg.sv
// ----------------------------------------------------------------------------
// ctb_pkg: countdown timer bank package
// Shared types, state codes and default sizes for the timer bank.
// ----------------------------------------------------------------------------
package ctb_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int KindW          = 3;
  localparam int SlotW          = 4;
  localparam int DurW           = 16;

  typedef enum logic [KindW-1:0] {
    KIND_TICK    = 3'd0,
    KIND_CREATE  = 3'd1,
    KIND_RESTART = 3'd2,
    KIND_STOP    = 3'd3,
    KIND_CHECK   = 3'd4
  } ctb_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SWEEP = 2'd1,
    ST_CHK   = 2'd2,
    ST_DONE  = 2'd3
  } ctb_state_e;

  // status from the datapath into the sequencer
  typedef struct packed {
    logic accept;
    logic is_tick;
    logic chk_go;
    logic sweep_done;
    logic out_free;
  } ctb_stat_t;

  // strobes from the sequencer into the datapath
  typedef struct packed {
    logic in_ready;
    logic sweep_en;
    logic chk_en;
    logic done;
  } ctb_ctrl_t;

  // result of the shared decrement and zero-test unit
  typedef struct packed {
    logic            expired;
    logic            wr_en;
    logic [DurW-1:0] dec;
  } ctb_unit_t;

endpackage

### rtl/core/ctb_req_if.sv
// ----------------------------------------------------------------------------
// ctb_req_if: timer bank command channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface ctb_req_if;
  logic                       valid;
  logic                       ready;
  logic [ctb_pkg::KindW-1:0]  kind;
  logic [ctb_pkg::SlotW-1:0]  slot;
  logic [ctb_pkg::DurW-1:0]   duration_ms;

  modport source (output valid, output kind, output slot, output duration_ms, input ready);
  modport sink (input valid, input kind, input slot, input duration_ms, output ready);
endinterface

### rtl/core/ctb_rsp_if.sv
// ----------------------------------------------------------------------------
// ctb_rsp_if: timer bank response channel
// Valid/ready channel carrying one response item.
// ----------------------------------------------------------------------------
interface ctb_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [ctb_pkg::SlotW-1:0]  slot_out;
  logic                       ok;
  logic                       expired;

  modport source (output valid, output slot_out, output ok, output expired, input ready);
  modport sink (input valid, input slot_out, input ok, input expired, output ready);
endinterface

### rtl/core/ctb_ram.sv
// ----------------------------------------------------------------------------
// ctb_ram: generic dual-port ram
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ctb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/ctb_unit.sv
// ----------------------------------------------------------------------------
// ctb_unit: shared count unit
// Zero test and decrement of one count, used by the tick sweep and by check.
// ----------------------------------------------------------------------------
module ctb_unit (
  input  logic                      run_i,
  input  logic [ctb_pkg::DurW-1:0]  count_i,
  output ctb_pkg::ctb_unit_t        res_o
);

  logic zero;

  assign zero = (count_i == '0);

  always_comb begin
    res_o.expired = run_i & zero;
    res_o.wr_en   = run_i & ~zero;
    res_o.dec     = count_i - ctb_pkg::DurW'(1);
  end

endmodule

### rtl/core/ctb_ctrl.sv
// ----------------------------------------------------------------------------
// ctb_ctrl: timer bank sequencer
// Steps each command through the tick sweep or the check read, as needed, and response hand-off.
// ----------------------------------------------------------------------------
module ctb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctb_pkg::ctb_stat_t  stat_i,
  output ctb_pkg::ctb_ctrl_t  ctrl_o,
  output ctb_pkg::ctb_state_e state_o
);

  ctb_pkg::ctb_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ctb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ctb_pkg::ST_IDLE: begin
        if (stat_i.accept) begin
          if (stat_i.is_tick) begin
            state_d = ctb_pkg::ST_SWEEP;
          end else if (stat_i.chk_go) begin
            state_d = ctb_pkg::ST_CHK;
          end else begin
            state_d = ctb_pkg::ST_DONE;
          end
        end
      end
      ctb_pkg::ST_SWEEP: begin
        if (stat_i.sweep_done) begin
          state_d = ctb_pkg::ST_DONE;
        end
      end
      ctb_pkg::ST_CHK: begin
        state_d = ctb_pkg::ST_DONE;
      end
      ctb_pkg::ST_DONE: begin
        if (stat_i.out_free) begin
          state_d = ctb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ctb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    case (state_q)
      ctb_pkg::ST_IDLE:  ctrl_o.in_ready = 1'b1;
      ctb_pkg::ST_SWEEP: ctrl_o.sweep_en = 1'b1;
      ctb_pkg::ST_CHK:   ctrl_o.chk_en   = 1'b1;
      ctb_pkg::ST_DONE:  ctrl_o.done     = stat_i.out_free;
      default:           ctrl_o          = '0;
    endcase
  end

  assign state_o = state_q;

endmodule

### rtl/core/soft_countdown_timer_bank.sv
// ----------------------------------------------------------------------------
// soft_countdown_timer_bank: bank of millisecond countdown timers
// Commands tick, create, restart, stop and check a bank of timers whose
// counts sit in a ram and are swept one slot per cycle on each tick.
// ----------------------------------------------------------------------------
//   channel | dir | handshake     | payload
//   req_i   | in  | valid / ready | kind, slot, duration_ms
//   rsp_o   | out | valid / ready | slot_out, ok, expired
//
// a tick sweeps the count ram after accept: its read port visits each created
// slot once, with write-back in the cycle after each read, and the sequencer
// waits for the last write-back to finish; create, restart, stop and bad
// commands go straight to the response, a valid check after its slot read
// rst_ni clears the running flags, the create count and the sequencer
// a response waits in the output register; the next item is taken once the
// previous response has moved into it
// ----------------------------------------------------------------------------
module soft_countdown_timer_bank #(
  parameter int NUM_TIMERS = ctb_pkg::NUM_TIMERS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ctb_req_if.sink    req_i,
  ctb_rsp_if.source  rsp_o
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W = $clog2(NUM_TIMERS + 1);
  localparam int CMP_W = (CNT_W > ctb_pkg::SlotW) ? CNT_W : ctb_pkg::SlotW;

  ctb_pkg::ctb_stat_t  stat;
  ctb_pkg::ctb_ctrl_t  ctrl;
  ctb_pkg::ctb_state_e state;
  ctb_pkg::ctb_unit_t  unit_res;
  ctb_pkg::ctb_kind_e  kind;

  logic [NUM_TIMERS-1:0]        running_q;
  logic [CNT_W-1:0]             created_q;
  logic [CNT_W-1:0]             cnt_q;
  logic [IDX_W-1:0]             rd_idx_q;
  logic                         rd_pend_q;

  logic [ctb_pkg::SlotW-1:0]    res_slot_q;
  logic                         res_ok_q;
  logic                         res_exp_q;

  logic                         out_valid_q;
  logic [ctb_pkg::SlotW-1:0]    out_slot_q;
  logic                         out_ok_q;
  logic                         out_exp_q;

  logic                         accept;
  logic                         slot_ok;
  logic                         full;
  logic [IDX_W-1:0]             slot_idx;
  logic [IDX_W-1:0]             new_idx;
  logic                         issue;
  logic                         wb;
  logic                         do_create;
  logic                         do_restart;
  logic                         do_stop;

  logic                         ram_we;
  logic [IDX_W-1:0]             ram_waddr;
  logic [ctb_pkg::DurW-1:0]     ram_wdata;
  logic [IDX_W-1:0]             ram_raddr;
  logic [ctb_pkg::DurW-1:0]     ram_rdata;

  // command decode
  assign kind     = ctb_pkg::ctb_kind_e'(req_i.kind);
  assign accept   = req_i.valid & ctrl.in_ready;
  assign slot_ok  = CMP_W'(req_i.slot) < CMP_W'(NUM_TIMERS);
  assign full     = (created_q == CNT_W'(NUM_TIMERS));
  assign slot_idx = IDX_W'(req_i.slot);
  assign new_idx  = created_q[IDX_W-1:0];

  assign do_create  = accept & (kind == ctb_pkg::KIND_CREATE) & ~full;
  assign do_restart = accept & (kind == ctb_pkg::KIND_RESTART) & slot_ok;
  assign do_stop    = accept & (kind == ctb_pkg::KIND_STOP) & slot_ok;

  // sweep: read slot cnt_q, write back the slot read in the previous cycle
  assign issue = ctrl.sweep_en & (cnt_q < created_q);
  assign wb    = rd_pend_q & unit_res.wr_en;

  always_comb begin
    stat.accept     = accept;
    stat.is_tick    = (kind == ctb_pkg::KIND_TICK);
    stat.chk_go     = (kind == ctb_pkg::KIND_CHECK) & slot_ok;
    stat.sweep_done = ctrl.sweep_en & ~issue & ~rd_pend_q;
    stat.out_free   = ~out_valid_q | rsp_o.ready;
  end

  ctb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .state_o (state)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_idx_q;
    ram_wdata = unit_res.dec;
    if (do_create) begin
      ram_we    = 1'b1;
      ram_waddr = new_idx;
      ram_wdata = req_i.duration_ms;
    end else if (do_restart) begin
      ram_we    = 1'b1;
      ram_waddr = slot_idx;
      ram_wdata = req_i.duration_ms;
    end else if (wb) begin
      ram_we    = 1'b1;
    end
  end

  assign ram_raddr = accept ? slot_idx : cnt_q[IDX_W-1:0];

  ctb_ram #(
    .WIDTH (ctb_pkg::DurW),
    .DEPTH (NUM_TIMERS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ctb_unit u_unit (
    .run_i   (running_q[rd_idx_q]),
    .count_i (ram_rdata),
    .res_o   (unit_res)
  );

  // counts are only looked at while running, and running implies loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= '0;
      created_q <= '0;
    end else begin
      if (do_create) begin
        running_q[new_idx] <= 1'b1;
        created_q          <= created_q + CNT_W'(1);
      end else if (do_restart) begin
        running_q[slot_idx] <= 1'b1;
      end else if (do_stop) begin
        running_q[slot_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      rd_pend_q <= 1'b0;
      rd_idx_q  <= '0;
    end else begin
      rd_pend_q <= issue;
      if (accept) begin
        cnt_q    <= '0;
        rd_idx_q <= slot_idx;
      end else if (issue) begin
        cnt_q    <= cnt_q + CNT_W'(1);
        rd_idx_q <= cnt_q[IDX_W-1:0];
      end
    end
  end

  // pending response, filled at accept and by the check read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_slot_q <= req_i.slot;
      res_exp_q  <= 1'b0;
      case (kind)
        ctb_pkg::KIND_TICK: res_ok_q <= 1'b1;
        ctb_pkg::KIND_CREATE: begin
          res_ok_q   <= ~full;
          res_slot_q <= full ? '0 : ctb_pkg::SlotW'(created_q);
        end
        ctb_pkg::KIND_RESTART: res_ok_q <= slot_ok;
        ctb_pkg::KIND_STOP:    res_ok_q <= slot_ok;
        ctb_pkg::KIND_CHECK:   res_ok_q <= slot_ok;
        default:               res_ok_q <= 1'b0;
      endcase
    end else if (ctrl.chk_en) begin
      res_exp_q <= unit_res.expired;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.done) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.done) begin
      out_slot_q <= res_slot_q;
      out_ok_q   <= res_ok_q;
      out_exp_q  <= res_exp_q;
    end
  end

  assign req_i.ready    = ctrl.in_ready;
  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.slot_out = out_slot_q;
  assign rsp_o.ok       = out_ok_q;
  assign rsp_o.expired  = out_exp_q;

  // checks

  a_create_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_create |=> (created_q == $past(created_q) + CNT_W'(1)))
    else $error("create count did not advance");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    created_q <= CNT_W'(NUM_TIMERS))
    else $error("create count beyond bank size");

  a_sweep_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb |-> (state == ctb_pkg::ST_SWEEP) && (CNT_W'(rd_idx_q) < created_q))
    else $error("sweep write-back outside created slots");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !req_i.ready)
    else $error("ready right after an accepted item");

endmodule
